[rtl/core/hsl_to_rgb_converter_defines.svh]
// ----------------------------------------------------------------------------
// hsl to rgb converter assertion macros
// concurrent assertion wrappers on clk_i, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsl to rgb converter assertion failed");
`define HSL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hsl to rgb converter assertion failed");
`else
`define HSL_ASSERT(lbl, prop)
`define HSL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// hsl to rgb converter package
// fixed-point formats, turn constants, stage map and the percent table
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int HUE_W     = 10;
  localparam int PCT_W     = 7;
  localparam int CH_W      = 8;
  localparam int FAC_W     = 7;

  localparam logic [FX_W-1:0] ONE_FX  = FX_W'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0] HALF_FX = ONE_FX >> 1;

  localparam logic [HUE_W-1:0] TURN            = HUE_W'(720);
  localparam logic [HUE_W-1:0] SIXTH_TURN      = HUE_W'(120);
  localparam logic [HUE_W-1:0] THIRD_TURN      = HUE_W'(240);
  localparam logic [HUE_W-1:0] HALF_TURN       = HUE_W'(360);
  localparam logic [HUE_W-1:0] TWO_THIRDS_TURN = HUE_W'(480);

  // division by 120 as a shift by 3 then a reciprocal multiply by 1/15
  localparam int DIV_PRE_SHIFT = 3;
  localparam int RECIP_SHIFT   = FRAC_BITS + 8;
  localparam int RECIP_W       = RECIP_SHIFT - 3;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SHIFT) / 15) + 1);

  localparam int DF_W = FX_W + FAC_W;
  localparam int Y_W  = DF_W - DIV_PRE_SHIFT;
  localparam int YM_W = Y_W + RECIP_W;

  localparam int PCT_MAX   = 100;
  localparam int PCT_LUT_N = 1 << PCT_W;

  localparam int ST_PREP    = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_PQ      = 2;
  localparam int ST_FAC     = 3;
  localparam int ST_DF      = 4;
  localparam int ST_RECIP   = 5;
  localparam int ST_SUM     = 6;
  localparam int ST_OUT     = 7;
  localparam int NUM_STAGES = 8;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [HUE_W-1:0] blue;
    logic [HUE_W-1:0] green;
    logic [HUE_W-1:0] red;
  } hue_set_t;

  typedef logic [FX_W-1:0] pct_lut_t [PCT_LUT_N];

  // percent to fraction, saturated at full scale
  function automatic pct_lut_t build_pct_lut();
    pct_lut_t lut;
    longint unsigned pct;
    for (int i = 0; i < PCT_LUT_N; i++) begin
      pct = (i > PCT_MAX) ? longint'(PCT_MAX) : longint'(i);
      lut[i] = FX_W'((pct << FRAC_BITS) / PCT_MAX);
    end
    return lut;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();

endpackage

[rtl/core/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsl to rgb converter
// one hsl colour per transfer in, one 8-bit rgb colour per transfer out
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields (low bit up)
//  s_axis   in         hue_half_deg[9:0] sat_percent[16:10] light_percent[23:17]
//  m_axis   out        red[7:0] green[15:8] blue[23:16]
//
//  one transfer per clock sustained while m_axis_tready is high; tvalid follows the
//  input transfer through the eight register stages: lookup, l*s multiply, p/q,
//  ramp factor, ramp multiply, reciprocal multiply, sum, scale to byte
//  reset clears the stage valid bits only; no clearing pass
//  each stage holds under a stall only while the one after it is full,
//  so bubbles close up and s_axis_tready stays high while any stage is empty
module hsl_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hue_half_deg, sat_percent, light_percent
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red, green, blue
);
  import hsl_pkg::*;

  pipe_ctrl_t      ctrl;
  logic [FX_W-1:0] l, s, p, q;
  logic            sat_zero;
  hue_set_t        hue1, hue3;
  logic [CH_W-1:0] red, green, blue;

  hsl_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  hsl_prep u_prep (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .hue_i      (s_axis_tdata[HUE_W-1:0]),
    .sat_i      (s_axis_tdata[HUE_W +: PCT_W]),
    .light_i    (s_axis_tdata[HUE_W+PCT_W +: PCT_W]),
    .l_o        (l),
    .s_o        (s),
    .sat_zero_o (sat_zero),
    .hue_o      (hue1)
  );

  hsl_pq u_pq (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .l_i        (l),
    .s_i        (s),
    .sat_zero_i (sat_zero),
    .hue_i      (hue1),
    .p_o        (p),
    .q_o        (q),
    .hue_o      (hue3)
  );

  hsl_channel u_red (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .p_i    (p),
    .q_i    (q),
    .hue_i  (hue3.red),
    .chan_o (red)
  );

  hsl_channel u_green (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .p_i    (p),
    .q_i    (q),
    .hue_i  (hue3.green),
    .chan_o (green)
  );

  hsl_channel u_blue (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .p_i    (p),
    .q_i    (q),
    .hue_i  (hue3.blue),
    .chan_o (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

[rtl/core/hsl_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// hsl pipeline control
// per-stage valid bits and load enables with stall back-propagation
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_defines.svh"

module hsl_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsl_pkg::pipe_ctrl_t ctrl_o
);
  import hsl_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d, en;
  logic                  in_fire, out_fire;

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign ctrl_o.en   = en;
  assign in_fire     = in_valid_i && en[0];
  assign out_fire    = valid_q[NUM_STAGES-1] && out_ready_i;

  `HSL_ASSERT(a_occ_up, in_fire && !out_fire |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
  `HSL_ASSERT(a_occ_down, out_fire && !in_fire |=> $countones(valid_q) == $past($countones(valid_q)) - 1)
  `HSL_ASSERT(a_bubble_accepts, !valid_q[0] |-> in_ready_o)
  `HSL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && valid_q == '0)

endmodule

[rtl/core/hsl_prep.sv]
// ----------------------------------------------------------------------------
// hsl input preparation
// percent to fraction lookup, hue wrap and the three shifted channel hues
// ----------------------------------------------------------------------------
module hsl_prep (
  input  logic                        clk_i,
  input  hsl_pkg::pipe_ctrl_t         ctrl_i,
  input  logic [hsl_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsl_pkg::PCT_W-1:0]   sat_i,
  input  logic [hsl_pkg::PCT_W-1:0]   light_i,
  output logic [hsl_pkg::FX_W-1:0]    l_o,
  output logic [hsl_pkg::FX_W-1:0]    s_o,
  output logic                        sat_zero_o,
  output hsl_pkg::hue_set_t           hue_o
);
  import hsl_pkg::*;

  logic [HUE_W-1:0] hue_w;
  hue_set_t         hue_d, hue_q;
  logic [FX_W-1:0]  l_q, s_q;
  logic             sat_zero_q;

  always_comb begin
    hue_w = (hue_i >= TURN) ? hue_i - TURN : hue_i;
    hue_d.green = hue_w;
    hue_d.red   = (hue_w >= TWO_THIRDS_TURN) ? hue_w - TWO_THIRDS_TURN : hue_w + THIRD_TURN;
    hue_d.blue  = (hue_w >= THIRD_TURN) ? hue_w - THIRD_TURN : hue_w + TWO_THIRDS_TURN;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_PREP]) begin
      l_q        <= PCT_LUT[light_i];
      s_q        <= PCT_LUT[sat_i];
      sat_zero_q <= (sat_i == '0);
      hue_q      <= hue_d;
    end
  end

  assign l_o        = l_q;
  assign s_o        = s_q;
  assign sat_zero_o = sat_zero_q;
  assign hue_o      = hue_q;

endmodule

[rtl/core/hsl_pq.sv]
// ----------------------------------------------------------------------------
// hsl p and q
// lightness by saturation product, then the q and p levels with clamping
// ----------------------------------------------------------------------------
module hsl_pq (
  input  logic                     clk_i,
  input  hsl_pkg::pipe_ctrl_t      ctrl_i,
  input  logic [hsl_pkg::FX_W-1:0] l_i,
  input  logic [hsl_pkg::FX_W-1:0] s_i,
  input  logic                     sat_zero_i,
  input  hsl_pkg::hue_set_t        hue_i,
  output logic [hsl_pkg::FX_W-1:0] p_o,
  output logic [hsl_pkg::FX_W-1:0] q_o,
  output hsl_pkg::hue_set_t        hue_o
);
  import hsl_pkg::*;

  localparam int M_W    = FX_W + 1;
  localparam int PROD_W = FX_W + M_W;

  logic              l_small;
  logic [M_W-1:0]    mult_b;
  logic [PROD_W-1:0] prod_q;
  logic [FX_W-1:0]   l2_q, s2_q;
  logic              small2_q, zero2_q;
  hue_set_t          hue2_q, hue3_q;

  logic [M_W-1:0]    shifted, q_raw, two_l, p_raw;
  logic [FX_W-1:0]   q_c, p_c, p_q, q_q;

  // stage two: one multiplier, l*(1+s) below half lightness, l*s above
  always_comb begin
    l_small = (l_i < HALF_FX);
    mult_b  = l_small ? ({1'b0, ONE_FX} + {1'b0, s_i}) : {1'b0, s_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_MUL]) begin
      prod_q   <= PROD_W'(l_i) * PROD_W'(mult_b);
      l2_q     <= l_i;
      s2_q     <= s_i;
      small2_q <= l_small;
      zero2_q  <= sat_zero_i;
      hue2_q   <= hue_i;
    end
  end

  // stage three: q, p, gray forces both to lightness
  always_comb begin
    shifted = prod_q[FRAC_BITS +: M_W];
    q_raw   = small2_q ? shifted : ({1'b0, l2_q} + {1'b0, s2_q} - shifted);
    q_c     = (q_raw > {1'b0, ONE_FX}) ? ONE_FX : q_raw[FX_W-1:0];
    two_l   = {l2_q, 1'b0};
    p_raw   = two_l - {1'b0, q_c};
    if ({1'b0, q_c} > two_l) begin
      p_c = '0;
    end else if (p_raw > {1'b0, ONE_FX}) begin
      p_c = ONE_FX;
    end else begin
      p_c = p_raw[FX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_PQ]) begin
      p_q    <= zero2_q ? l2_q : p_c;
      q_q    <= zero2_q ? l2_q : q_c;
      hue3_q <= hue2_q;
    end
  end

  assign p_o   = p_q;
  assign q_o   = q_q;
  assign hue_o = hue3_q;

endmodule

[rtl/core/hsl_channel.sv]
// ----------------------------------------------------------------------------
// hsl channel
// piecewise hue ramp, divide by a sixth turn, scale to an 8-bit channel
// ----------------------------------------------------------------------------
module hsl_channel (
  input  logic                      clk_i,
  input  hsl_pkg::pipe_ctrl_t       ctrl_i,
  input  logic [hsl_pkg::FX_W-1:0]  p_i,
  input  logic [hsl_pkg::FX_W-1:0]  q_i,
  input  logic [hsl_pkg::HUE_W-1:0] hue_i,
  output logic [hsl_pkg::CH_W-1:0]  chan_o
);
  import hsl_pkg::*;

  localparam int SCALE_W = FX_W + CH_W;

  logic [FAC_W-1:0]   fac_d, fac_q;
  logic [HUE_W-1:0]   fall;
  logic [FX_W-1:0]    d_q, p4_q, p5_q, p6_q, v_q;
  logic [DF_W-1:0]    df_q;
  logic [YM_W-1:0]    ym_q;
  logic [Y_W-1:0]     y;
  logic [SCALE_W-1:0] scaled;
  logic [CH_W-1:0]    chan_q;

  always_comb begin
    fall = TWO_THIRDS_TURN - hue_i;
    priority if (hue_i < SIXTH_TURN) begin
      fac_d = hue_i[FAC_W-1:0];
    end else if (hue_i < HALF_TURN) begin
      fac_d = SIXTH_TURN[FAC_W-1:0];
    end else if (hue_i < TWO_THIRDS_TURN) begin
      fac_d = fall[FAC_W-1:0];
    end else begin
      fac_d = '0;
    end
  end

  assign y      = df_q[DF_W-1:DIV_PRE_SHIFT];
  assign scaled = {v_q, {CH_W{1'b0}}} - {{CH_W{1'b0}}, v_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_FAC]) begin
      d_q   <= (q_i > p_i) ? q_i - p_i : '0;
      fac_q <= fac_d;
      p4_q  <= p_i;
    end
    if (ctrl_i.en[ST_DF]) begin
      df_q <= DF_W'(d_q) * DF_W'(fac_q);
      p5_q <= p4_q;
    end
    if (ctrl_i.en[ST_RECIP]) begin
      ym_q <= YM_W'(y) * YM_W'(RECIP_M);
      p6_q <= p5_q;
    end
    if (ctrl_i.en[ST_SUM]) begin
      v_q <= p6_q + ym_q[RECIP_SHIFT +: FX_W];
    end
    if (ctrl_i.en[ST_OUT]) begin
      chan_q <= scaled[FRAC_BITS +: CH_W];
    end
  end

  assign chan_o = chan_q;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// hsl to rgb converter testbench
// drives hsl colours through the s_axis stream under random bursts and gaps,
// stalls the m_axis side on its own pattern, and checks each rgb transfer
// against a fixed-point predictor of the piecewise hue rule
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB         = hsl_pkg::FRAC_BITS;
  localparam longint UNIT       = longint'(1) << FB;
  localparam longint FULL_TURN  = 720;
  localparam longint RAMP_END   = 120;
  localparam longint PLATEAU    = 360;
  localparam longint FALL_END   = 480;
  localparam longint SHIFT      = 240;
  localparam int     IDLE_LIMIT = 5000;
  localparam int     RANDOM_N   = 1800;

  typedef struct packed {
    logic [hsl_pkg::PCT_W-1:0] light;
    logic [hsl_pkg::PCT_W-1:0] sat;
    logic [hsl_pkg::HUE_W-1:0] hue;
  } hsl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  class colour_scoreboard;
    rgb_t        expected_colours[$];
    int unsigned errors = 0;

    function logic [7:0] frac_to_byte(longint v);
      if (v < 0) v = 0;
      if (v > UNIT) v = UNIT;
      return 8'((v * 255) >>> FB);
    endfunction

    function longint hue_ramp(longint p, longint q, longint t);
      longint d;
      d = q - p;
      if (d < 0) d = 0;
      if (t < RAMP_END) return p + (d * t) / RAMP_END;
      if (t < PLATEAU) return q;
      if (t < FALL_END) return p + (d * (FALL_END - t)) / RAMP_END;
      return p;
    endfunction

    function rgb_t predict_rgb(hsl_t c);
      longint hue, sat, lit, s, l, q, p;
      rgb_t   o;
      hue = longint'(c.hue);
      sat = longint'(c.sat);
      lit = longint'(c.light);
      if (hue >= FULL_TURN) hue -= FULL_TURN;
      if (sat > 100) sat = 100;
      if (lit > 100) lit = 100;
      s = (sat * UNIT) / 100;
      l = (lit * UNIT) / 100;
      if (sat == 0) begin
        o.red   = frac_to_byte(l);
        o.green = o.red;
        o.blue  = o.red;
        return o;
      end
      if (l < UNIT / 2) q = (l * (UNIT + s)) >>> FB;
      else q = l + s - ((l * s) >>> FB);
      if (q < 0) q = 0;
      if (q > UNIT) q = UNIT;
      p = 2 * l - q;
      if (p < 0) p = 0;
      if (p > UNIT) p = UNIT;
      o.red   = frac_to_byte(hue_ramp(p, q, (hue + SHIFT) % FULL_TURN));
      o.green = frac_to_byte(hue_ramp(p, q, hue));
      o.blue  = frac_to_byte(hue_ramp(p, q, (hue + FULL_TURN - SHIFT) % FULL_TURN));
      return o;
    endfunction

    function void note_colour(hsl_t c);
      expected_colours.push_back(predict_rgb(c));
    endfunction

    function void check_colour(rgb_t got);
      rgb_t want;
      if (expected_colours.size() == 0) begin
        $display("%0t unexpected output transfer: expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_colours.pop_front();
      if (got.red !== want.red) begin
        $display("%0t red mismatch: expected %0d, got %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t green mismatch: expected %0d, got %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t blue mismatch: expected %0d, got %0d", $time, want.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_colours.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;

  colour_scoreboard sb = new();
  int          idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;

  always #1 clk_i = ~clk_i;

  hsl_to_rgb_converter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // receiver stall pattern, mode changes after a random stretch
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_phase[3:0] == 4'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) sb.check_colour(rgb_t'(m_axis_tdata));
    if (rst_ni && ((m_axis_tvalid && m_tready) || (s_tvalid && s_axis_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_colour(input int hue, input int sat, input int light);
    hsl_t c;
    c.hue   = hsl_pkg::HUE_W'(hue);
    c.sat   = hsl_pkg::PCT_W'(sat);
    c.light = hsl_pkg::PCT_W'(light);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_colour(c);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_colours();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_colour();
    int hue, sat, light;
    hue   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 719);
    case ($urandom_range(0, 9))
      0:       sat = 0;
      1:       sat = $urandom_range(101, 127);
      default: sat = $urandom_range(1, 100);
    endcase
    light = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    send_colour(hue, sat, light);
  endtask

  initial begin
    int sent, burst, gap;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, hue segment edges, wrap and saturation cases
    send_colour(0, 100, 50);
    send_colour(119, 100, 50);
    send_colour(120, 100, 50);
    send_colour(239, 100, 50);
    send_colour(240, 100, 50);
    send_colour(359, 100, 50);
    send_colour(360, 100, 50);
    send_colour(479, 100, 50);
    send_colour(480, 100, 50);
    send_colour(719, 100, 50);
    send_colour(720, 100, 50);
    send_colour(1023, 100, 50);
    send_colour(300, 0, 0);
    send_colour(300, 0, 100);
    send_colour(300, 0, 127);
    send_colour(300, 0, 37);
    send_colour(100, 1, 1);
    send_colour(600, 127, 49);
    send_colour(200, 101, 51);
    send_colour(400, 100, 0);
    send_colour(50, 100, 100);
    send_colour(900, 127, 127);
    send_colour(960, 64, 25);
    send_colour(840, 80, 75);
    drain_colours();

    sent = 0;
    while (sent < RANDOM_N) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_N; i++) begin
        send_random_colour();
        sent++;
        if (sent == RANDOM_N / 2) drain_colours();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_gap(gap);
    end

    drain_colours();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
